/* src/accel_fall_detector_unit_assert.svh */
// Assertion macros shared by the fall detector's checkers.
// Each use expects clk_i, and AFD_ASSERT also rst_ni, to be visible in the enclosing scope.
`ifndef ACCEL_FALL_DETECTOR_UNIT_ASSERT_SVH
`define ACCEL_FALL_DETECTOR_UNIT_ASSERT_SVH

// Concurrent assertion that is switched off while reset is applied.
`define AFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Concurrent assertion that also holds during reset.
`define AFD_ASSERT_AR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* src/afd_pkg.sv */
// Types and constants of the fall detector.
// No dependencies; every other file but the assertion header imports this package.
`default_nettype none

package afd_pkg;

  // Field widths.
  localparam int unsigned AccelW = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned LevelW = 17;
  localparam int unsigned MsW    = 16;
  localparam int unsigned CfgIdxW = 3;
  // Squared level: 17 bits squared.
  localparam int unsigned LevelSqW = 2 * LevelW;
  // Squared component fits 31 bits unsigned, a sum of three fits 32.
  localparam int unsigned SqW  = 31;
  localparam int unsigned NormW = 32;
  // Signed dot product term and its sum over three axes.
  localparam int unsigned PrW  = 32;
  localparam int unsigned DotW = 33;
  localparam int unsigned WideW = 64;

  typedef logic signed [AccelW-1:0] accel_t;
  typedef logic [TimeW-1:0]         time_t;
  typedef logic [LevelW-1:0]        level_t;
  typedef logic [MsW-1:0]           ms_t;
  typedef logic [LevelSqW-1:0]      level_sq_t;

  // Reset values of the configuration registers.
  localparam level_t FreefallLevelRst = 17'd4915;
  localparam level_t ImpactLevelRst   = 17'd49152;
  localparam level_t ViolentLevelRst  = 17'd73728;
  localparam level_t StableLowRst     = 17'd13926;
  localparam level_t StableHighRst    = 17'd18842;
  localparam ms_t    FfWindowRst      = 16'd500;
  localparam ms_t    OrientDelayRst   = 16'd200;
  // Reference orientation after reset: one g along Z.
  localparam accel_t StableZRst       = 16'sd16384;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_FREEFALL_LEVEL  = 3'd0,
    CFG_IMPACT_LEVEL    = 3'd1,
    CFG_VIOLENT_LEVEL   = 3'd2,
    CFG_STABLE_LOW      = 3'd3,
    CFG_STABLE_HIGH     = 3'd4,
    CFG_FF_WINDOW_MS    = 3'd5,
    CFG_ORIENT_DELAY_MS = 3'd6
  } cfg_idx_e;

  // Event codes reported with each result item.
  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_FREEFALL = 3'd1,
    EV_IMPACT   = 3'd2,
    EV_TIMEOUT  = 3'd3,
    EV_FALL     = 3'd4,
    EV_SMALL    = 3'd5,
    EV_VIOLENT  = 3'd6
  } event_e;

  // Detector state, one-hot.
  typedef enum logic [2:0] {
    MODE_IDLE      = 3'b001,
    MODE_MAYBE_FF  = 3'b010,
    MODE_MAYBE_IMP = 3'b100
  } mode_e;

  // Mode codes as reported on the result channel.
  localparam logic [1:0] MODE_CODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_CODE_FF   = 2'd1;
  localparam logic [1:0] MODE_CODE_IMP  = 2'd2;

  // Per-axis lane products.
  typedef struct packed {
    logic [SqW-1:0]        sq;  // current component squared
    logic [SqW-1:0]        rr;  // reference component squared
    logic signed [PrW-1:0] pr;  // current times reference
  } lane_t;

  // Merged lane sums.
  typedef struct packed {
    logic [NormW-1:0]       m2;  // squared norm of the sample
    logic [NormW-1:0]       n1;  // squared norm of the reference
    logic signed [DotW-1:0] d;   // dot product
  } sum_t;

  // Angle test operands.
  typedef struct packed {
    logic [WideW-1:0] dd;     // dot product squared
    logic [WideW-1:0] p;      // product of the squared norms
    logic             d_neg;  // dot product below zero
    logic             zero;   // one of the norms is zero
  } prod_t;

  // Squared levels derived from the configuration.
  typedef struct packed {
    level_sq_t ff;
    level_sq_t imp;
    level_sq_t vio;
    level_sq_t lo;
    level_sq_t hi;
  } lvl_sq_t;

  // Reported code of a mode.
  function automatic logic [1:0] mode_code(mode_e m);
    logic [1:0] c;
    unique case (m)
      MODE_IDLE:      c = MODE_CODE_IDLE;
      MODE_MAYBE_FF:  c = MODE_CODE_FF;
      MODE_MAYBE_IMP: c = MODE_CODE_IMP;
      default:        c = MODE_CODE_IDLE;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* src/afd_if.sv */
// Handshake channels of the fall detector: samples, results and configuration.
// Depends on afd_pkg.
`default_nettype none

interface afd_sample_if;
  import afd_pkg::*;
  logic   valid;
  logic   ready;
  accel_t accel_x;
  accel_t accel_y;
  accel_t accel_z;
  time_t  time_ms;

  modport source (output valid, accel_x, accel_y, accel_z, time_ms, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, time_ms, output ready);
endinterface

interface afd_result_if;
  logic       valid;
  logic       ready;
  logic       fall_detected;
  logic [2:0] event_code;
  logic [1:0] detector_mode;

  modport source (output valid, fall_detected, event_code, detector_mode, input ready);
  modport sink   (input valid, fall_detected, event_code, detector_mode, output ready);
endinterface

interface afd_cfg_if;
  import afd_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  level_t             data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* src/afd_lane.sv */
// One axis lane: squares of the sample and reference components and their product.
// Depends on afd_pkg.
`default_nettype none

module afd_lane
  import afd_pkg::*;
(
  input  logic   clk_i,
  input  accel_t cur_i,
  input  accel_t ref_i,
  output lane_t  lane_o
);

  logic signed [PrW-1:0] sq_full;
  logic signed [PrW-1:0] rr_full;
  logic signed [PrW-1:0] pr_full;
  lane_t                 lane_d;
  lane_t                 lane_q;

  // Three 16 by 16 signed products; squares are never negative.
  always_comb begin
    sq_full     = PrW'(cur_i) * PrW'(cur_i);
    rr_full     = PrW'(ref_i) * PrW'(ref_i);
    pr_full     = PrW'(cur_i) * PrW'(ref_i);
    lane_d.sq   = sq_full[SqW-1:0];
    lane_d.rr   = rr_full[SqW-1:0];
    lane_d.pr   = pr_full;
  end

  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
  end

  assign lane_o = lane_q;

endmodule

`default_nettype wire

/* src/afd_merge.sv */
// Merge stage: sums the three lanes, then forms the angle test products.
// Depends on afd_pkg.
`default_nettype none

module afd_merge
  import afd_pkg::*;
(
  input  logic  clk_i,
  input  lane_t lane_x_i,
  input  lane_t lane_y_i,
  input  lane_t lane_z_i,
  output sum_t  sum_o,
  output prod_t prod_o
);

  sum_t             sum_d;
  sum_t             sum_q;
  prod_t            prod_d;
  prod_t            prod_q;
  logic [NormW-1:0] abs_d;

  // Sum the lane results into norms and the dot product.
  always_comb begin
    sum_d.m2 = {1'b0, lane_x_i.sq} + {1'b0, lane_y_i.sq} + {1'b0, lane_z_i.sq};
    sum_d.n1 = {1'b0, lane_x_i.rr} + {1'b0, lane_y_i.rr} + {1'b0, lane_z_i.rr};
    sum_d.d  = {lane_x_i.pr[PrW-1], lane_x_i.pr}
             + {lane_y_i.pr[PrW-1], lane_y_i.pr}
             + {lane_z_i.pr[PrW-1], lane_z_i.pr};
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  // A non-negative dot product fits 32 bits; a negative one needs no square.
  always_comb begin
    abs_d        = sum_q.d[NormW-1:0];
    prod_d.dd    = WideW'(abs_d) * WideW'(abs_d);
    prod_d.p     = WideW'(sum_q.n1) * WideW'(sum_q.m2);
    prod_d.d_neg = sum_q.d[DotW-1];
    prod_d.zero  = (sum_q.n1 == '0) || (sum_q.m2 == '0);
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign sum_o  = sum_q;
  assign prod_o = prod_q;

endmodule

`default_nettype wire

/* src/accel_fall_detector_unit.sv */
// Fall detector top level: three axis lanes, a merge stage and the detection state machine.
// An item passes the input, lane, sum and product registers, then the result register.
// A new item is taken only once the pipeline is empty or its item commits; the state and
// reference written as an item completes feed the lanes of the next item.
// Reset (rst_ni low, asynchronous) restores configuration, state and an empty pipeline.
// Depends on afd_pkg, afd_if, afd_lane and afd_merge.
`default_nettype none

module accel_fall_detector_unit
  import afd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  afd_sample_if.sink   in_i,
  afd_result_if.source out_o,
  afd_cfg_if.sink      cfg_i
);

  // Configuration registers.
  level_t ff_level_q, imp_level_q, vio_level_q, st_low_q, st_high_q;
  ms_t    ff_window_q, orient_delay_q;
  lvl_sq_t lvl_sq_q;

  // Detector state.
  mode_e  mode_q, mode_d;
  time_t  ff_start_q, ff_start_d;
  time_t  imp_time_q, imp_time_d;
  accel_t st_x_q, st_y_q, st_z_q;
  accel_t st_x_d, st_y_d, st_z_d;

  // Pipeline.
  logic [3:0] vld_q, vld_d;
  accel_t     in_x_q, in_y_q, in_z_q;
  time_t      in_t_q;
  lane_t      lane_x, lane_y, lane_z;
  sum_t       sum;
  prod_t      prod;

  // Level and time flags, aligned with the product stage.
  logic ff_lvl_q, imp_lvl_q, vio_lvl_q, band_q, ff_exp_q, delay_done_q;
  logic [TimeW-1:0] ff_elapsed, imp_elapsed;

  logic   accept;
  logic   commit;
  logic   wide;
  logic   fall_d, fall_q;
  event_e ev_d, ev_q;
  logic   out_valid_q;

  // Configuration port: always ready, unknown indexes are ignored.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ff_level_q     <= FreefallLevelRst;
      imp_level_q    <= ImpactLevelRst;
      vio_level_q    <= ViolentLevelRst;
      st_low_q       <= StableLowRst;
      st_high_q      <= StableHighRst;
      ff_window_q    <= FfWindowRst;
      orient_delay_q <= OrientDelayRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_FREEFALL_LEVEL:  ff_level_q     <= cfg_i.data;
        CFG_IMPACT_LEVEL:    imp_level_q    <= cfg_i.data;
        CFG_VIOLENT_LEVEL:   vio_level_q    <= cfg_i.data;
        CFG_STABLE_LOW:      st_low_q       <= cfg_i.data;
        CFG_STABLE_HIGH:     st_high_q      <= cfg_i.data;
        CFG_FF_WINDOW_MS:    ff_window_q    <= cfg_i.data[MsW-1:0];
        CFG_ORIENT_DELAY_MS: orient_delay_q <= cfg_i.data[MsW-1:0];
        default: ;
      endcase
    end
  end

  // Squared levels follow the configuration in the next cycle.
  always_ff @(posedge clk_i) begin
    lvl_sq_q.ff  <= LevelSqW'(ff_level_q) * LevelSqW'(ff_level_q);
    lvl_sq_q.imp <= LevelSqW'(imp_level_q) * LevelSqW'(imp_level_q);
    lvl_sq_q.vio <= LevelSqW'(vio_level_q) * LevelSqW'(vio_level_q);
    lvl_sq_q.lo  <= LevelSqW'(st_low_q) * LevelSqW'(st_low_q);
    lvl_sq_q.hi  <= LevelSqW'(st_high_q) * LevelSqW'(st_high_q);
  end

  // Handshake: one item in flight; the result register parts the output side.
  assign commit     = vld_q[3] && (!out_valid_q || out_o.ready);
  assign in_i.ready = (vld_q == '0) || commit;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    vld_d[0] = accept;
    vld_d[1] = vld_q[0];
    vld_d[2] = vld_q[1];
    vld_d[3] = vld_q[2] || (vld_q[3] && !commit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Input register, held for the whole item.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_x_q <= in_i.accel_x;
      in_y_q <= in_i.accel_y;
      in_z_q <= in_i.accel_z;
      in_t_q <= in_i.time_ms;
    end
  end

  // One lane per axis.
  afd_lane u_lane_x (.clk_i(clk_i), .cur_i(in_x_q), .ref_i(st_x_q), .lane_o(lane_x));
  afd_lane u_lane_y (.clk_i(clk_i), .cur_i(in_y_q), .ref_i(st_y_q), .lane_o(lane_y));
  afd_lane u_lane_z (.clk_i(clk_i), .cur_i(in_z_q), .ref_i(st_z_q), .lane_o(lane_z));

  afd_merge u_merge (
    .clk_i    (clk_i),
    .lane_x_i (lane_x),
    .lane_y_i (lane_y),
    .lane_z_i (lane_z),
    .sum_o    (sum),
    .prod_o   (prod)
  );

  // Level compares and elapsed times, registered beside the products.
  assign ff_elapsed  = in_t_q - ff_start_q;
  assign imp_elapsed = in_t_q - imp_time_q;

  always_ff @(posedge clk_i) begin
    ff_lvl_q     <= {2'b00, sum.m2} < lvl_sq_q.ff;
    imp_lvl_q    <= {2'b00, sum.m2} > lvl_sq_q.imp;
    vio_lvl_q    <= {2'b00, sum.m2} > lvl_sq_q.vio;
    band_q       <= ({2'b00, sum.m2} > lvl_sq_q.lo) && ({2'b00, sum.m2} < lvl_sq_q.hi);
    ff_exp_q     <= ff_elapsed > {{(TimeW-MsW){1'b0}}, ff_window_q};
    delay_done_q <= imp_elapsed >= {{(TimeW-MsW){1'b0}}, orient_delay_q};
  end

  // Angle wider than 45 degrees: negative dot product, or 2*d*d below n1*n2.
  assign wide = !prod.zero && (prod.d_neg || ({prod.dd, 1'b0} < {1'b0, prod.p}));

  // Detection state machine.
  always_comb begin
    mode_d     = mode_q;
    ff_start_d = ff_start_q;
    imp_time_d = imp_time_q;
    st_x_d     = st_x_q;
    st_y_d     = st_y_q;
    st_z_d     = st_z_q;
    ev_d       = EV_NONE;
    fall_d     = 1'b0;

    // While idle, a sample in the stable band becomes the reference.
    if (mode_q == MODE_IDLE && band_q) begin
      st_x_d = in_x_q;
      st_y_d = in_y_q;
      st_z_d = in_z_q;
    end

    unique case (mode_q)
      MODE_IDLE: begin
        if (ff_lvl_q) begin
          mode_d     = MODE_MAYBE_FF;
          ff_start_d = in_t_q;
          ev_d       = EV_FREEFALL;
        end
      end
      MODE_MAYBE_FF: begin
        // Impact takes precedence over the window timeout.
        if (imp_lvl_q) begin
          mode_d     = MODE_MAYBE_IMP;
          imp_time_d = in_t_q;
          ev_d       = EV_IMPACT;
        end else if (ff_exp_q) begin
          mode_d = MODE_IDLE;
          ev_d   = EV_TIMEOUT;
        end
      end
      MODE_MAYBE_IMP: begin
        // An expired delay is checked before violent motion.
        if (delay_done_q) begin
          mode_d = MODE_IDLE;
          if (wide) begin
            fall_d = 1'b1;
            ev_d   = EV_FALL;
          end else begin
            ev_d = EV_SMALL;
          end
        end else if (vio_lvl_q) begin
          mode_d = MODE_IDLE;
          ev_d   = EV_VIOLENT;
        end
      end
      default: begin
        mode_d = MODE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      ff_start_q <= '0;
      imp_time_q <= '0;
      st_x_q     <= '0;
      st_y_q     <= '0;
      st_z_q     <= StableZRst;
    end else if (commit) begin
      mode_q     <= mode_d;
      ff_start_q <= ff_start_d;
      imp_time_q <= imp_time_d;
      st_x_q     <= st_x_d;
      st_y_q     <= st_y_d;
      st_z_q     <= st_z_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      fall_q <= fall_d;
      ev_q   <= ev_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.fall_detected = fall_q;
  assign out_o.event_code    = ev_q;
  assign out_o.detector_mode = mode_code(mode_q);

endmodule

`default_nettype wire

/* src/afd_checker.sv */
// Port-level checks of the fall detector, bound to the top level.
// Depends on afd_pkg and accel_fall_detector_unit_assert.svh.
`default_nettype none

`include "accel_fall_detector_unit_assert.svh"

module afd_checker
  import afd_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic       out_fall_i,
  input wire logic [2:0] out_event_i,
  input wire logic [1:0] out_mode_i
);

  // A stalled result item stays put.
  `AFD_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_fall_i) && $stable(out_event_i) && $stable(out_mode_i), "result item changed while stalled")

  // Only one item is in flight, so an accepted item closes the input for a while.
  `AFD_ASSERT(a_one_in_flight, in_valid_i && in_ready_i |=> !in_ready_i, "second item accepted while one is in flight")

  // The fall flag agrees with the event code.
  `AFD_ASSERT_AR(a_fall_code, out_valid_i |-> (out_fall_i == (out_event_i == EV_FALL)), "fall flag and event code disagree")

  // Events that end a detection leave the detector idle.
  `AFD_ASSERT_AR(a_end_idle, out_valid_i && (out_event_i == EV_TIMEOUT || out_event_i == EV_FALL || out_event_i == EV_SMALL || out_event_i == EV_VIOLENT) |-> out_mode_i == MODE_CODE_IDLE, "detection ended but mode is not idle")

  // Free fall and impact move the detector to their waiting modes.
  `AFD_ASSERT_AR(a_start_mode, out_valid_i && (out_event_i == EV_FREEFALL || out_event_i == EV_IMPACT) |-> out_mode_i == (out_event_i == EV_FREEFALL ? MODE_CODE_FF : MODE_CODE_IMP), "mode does not follow the event")

endmodule

bind accel_fall_detector_unit afd_checker u_afd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_fall_i  (out_o.fall_detected),
  .out_event_i (out_o.event_code),
  .out_mode_i  (out_o.detector_mode)
);

`default_nettype wire

/* verif/accel_fall_detector_unit_test.sv */
// Self-checking testbench of the fall detector: directed and random samples,
// register settings and handshake pacing, checked against an in-bench predictor.
// Depends on afd_pkg, afd_if and accel_fall_detector_unit.
`timescale 1ns / 100ps

module accel_fall_detector_unit_test
  import afd_pkg::*;
;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 8;
  // Index past the last register; a write there must change nothing.
  localparam logic [CfgIdxW-1:0] CfgUnusedIdx = 3'd7;

  // One expected result item.
  typedef struct packed {
    logic       fall;
    event_e     ev;
    logic [1:0] mode;
  } verdict_t;

  // One sample item as driven.
  typedef struct {
    accel_t x;
    accel_t y;
    accel_t z;
    time_t  t;
  } sample_t;

  // One full set of register values; the millisecond registers get 17 bits of data
  // so that the dropped top bit is exercised.
  typedef struct {
    level_t ff;
    level_t imp;
    level_t vio;
    level_t lo;
    level_t hi;
    level_t win;
    level_t dly;
  } settings_t;

  typedef enum int {
    KIND_STABLE,
    KIND_FREEFALL,
    KIND_IMPACT,
    KIND_VIOLENT,
    KIND_NOISE,
    KIND_ZERO
  } kind_e;

  typedef enum int {
    PACE_FULL,
    PACE_SENDER,
    PACE_RECEIVER,
    PACE_BOTH
  } pace_e;

  // Tracks the detector state and holds the verdicts still owed by the block.
  class fall_tracker;
    level_t      ff_lvl, imp_lvl, vio_lvl, band_lo, band_hi;
    ms_t         win_ms, dly_ms;
    logic [1:0]  mode_now;
    time_t       ff_start, imp_start;
    accel_t      ref_x, ref_y, ref_z;
    verdict_t    owed_q[$];
    int unsigned errors, samples, results;
    int unsigned ev_seen[8];

    function new();
      ff_lvl    = FreefallLevelRst;
      imp_lvl   = ImpactLevelRst;
      vio_lvl   = ViolentLevelRst;
      band_lo   = StableLowRst;
      band_hi   = StableHighRst;
      win_ms    = FfWindowRst;
      dly_ms    = OrientDelayRst;
      mode_now  = MODE_CODE_IDLE;
      ff_start  = '0;
      imp_start = '0;
      ref_x     = '0;
      ref_y     = '0;
      ref_z     = StableZRst;
      errors    = 0;
      samples   = 0;
      results   = 0;
      foreach (ev_seen[i]) ev_seen[i] = 0;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    function longint unsigned norm_sq(accel_t a, accel_t b, accel_t c);
      longint sa, sb, sc;
      sa = a;
      sb = b;
      sc = c;
      return longint'(sa * sa + sb * sb + sc * sc);
    endfunction

    function longint unsigned level_sq(level_t l);
      longint unsigned w;
      w = l;
      return w * w;
    endfunction

    // True when the angle to the reference exceeds 45 degrees.
    function logic tilted(accel_t x, accel_t y, accel_t z);
      longint unsigned n1, n2, ad, dd, p;
      longint d;
      logic [64:0] twice_dd;
      n1 = norm_sq(ref_x, ref_y, ref_z);
      n2 = norm_sq(x, y, z);
      d = longint'(ref_x) * longint'(x) + longint'(ref_y) * longint'(y)
        + longint'(ref_z) * longint'(z);
      if (n1 == 0 || n2 == 0) return 1'b0;
      if (d < 0) return 1'b1;
      ad = d;
      dd = ad * ad;
      p = n1 * n2;
      twice_dd = {dd, 1'b0};
      return twice_dd < {1'b0, p};
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, level_t data);
      case (idx)
        CFG_FREEFALL_LEVEL:  ff_lvl  = data;
        CFG_IMPACT_LEVEL:    imp_lvl = data;
        CFG_VIOLENT_LEVEL:   vio_lvl = data;
        CFG_STABLE_LOW:      band_lo = data;
        CFG_STABLE_HIGH:     band_hi = data;
        CFG_FF_WINDOW_MS:    win_ms  = ms_t'(data);
        CFG_ORIENT_DELAY_MS: dly_ms  = ms_t'(data);
        default: ;
      endcase
    endfunction

    // Advances the state by one accepted sample and queues its verdict.
    function void take_sample(accel_t x, accel_t y, accel_t z, time_t now);
      longint unsigned m2;
      verdict_t v;
      time_t elapsed;
      m2 = norm_sq(x, y, z);
      v.fall = 1'b0;
      v.ev = EV_NONE;
      // While idle the reference follows any sample inside the stable band.
      if (mode_now == MODE_CODE_IDLE && m2 > level_sq(band_lo) && m2 < level_sq(band_hi)) begin
        ref_x = x;
        ref_y = y;
        ref_z = z;
      end
      case (mode_now)
        MODE_CODE_IDLE: begin
          if (m2 < level_sq(ff_lvl)) begin
            mode_now = MODE_CODE_FF;
            ff_start = now;
            v.ev = EV_FREEFALL;
          end
        end
        MODE_CODE_FF: begin
          elapsed = now - ff_start;
          if (m2 > level_sq(imp_lvl)) begin
            mode_now = MODE_CODE_IMP;
            imp_start = now;
            v.ev = EV_IMPACT;
          end else if (elapsed > time_t'(win_ms)) begin
            mode_now = MODE_CODE_IDLE;
            v.ev = EV_TIMEOUT;
          end
        end
        MODE_CODE_IMP: begin
          elapsed = now - imp_start;
          if (elapsed >= time_t'(dly_ms)) begin
            if (tilted(x, y, z)) begin
              v.fall = 1'b1;
              v.ev = EV_FALL;
            end else begin
              v.ev = EV_SMALL;
            end
            mode_now = MODE_CODE_IDLE;
          end else if (m2 > level_sq(vio_lvl)) begin
            mode_now = MODE_CODE_IDLE;
            v.ev = EV_VIOLENT;
          end
        end
        default: mode_now = MODE_CODE_IDLE;
      endcase
      v.mode = mode_now;
      owed_q.push_back(v);
      ev_seen[int'(v.ev)]++;
      samples++;
    endfunction

    function void report(string what, int unsigned want, int unsigned got);
      $display("MISMATCH %s at result %0d: expected %0d, got %0d", what, results, want, got);
      errors++;
    endfunction

    function void match_verdict(logic fall, logic [2:0] ev, logic [1:0] mode);
      verdict_t v;
      results++;
      if (owed_q.size() == 0) begin
        report("result item with none pending", 0, ev);
        return;
      end
      v = owed_q.pop_front();
      if (fall !== v.fall) report("fall_detected", v.fall, fall);
      if (ev !== v.ev) report("event_code", v.ev, ev);
      if (mode !== v.mode) report("detector_mode", v.mode, mode);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        rx_ready = 1'b0;
  pace_e       pace = PACE_FULL;
  time_t       clock_ms = '0;
  int unsigned cycles = 0;
  int unsigned n_settings = 0;
  sample_t     stim_q[$];
  fall_tracker tracker = new();

  afd_sample_if in_if();
  afd_result_if out_if();
  afd_cfg_if    cfg_if();

  accel_fall_detector_unit uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Cycle budget for the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timed out after %0d cycles with %0d results pending", cycles, tracker.pending());
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic sender_idles();
    return (pace == PACE_SENDER && $urandom_range(0, 99) < 45) ||
           (pace == PACE_BOTH && $urandom_range(0, 99) < 6);
  endfunction

  function automatic logic receiver_stalls();
    return (pace == PACE_RECEIVER && $urandom_range(0, 99) < 45) ||
           (pace == PACE_BOTH && $urandom_range(0, 99) < 6);
  endfunction

  // Result side backpressure.
  assign out_if.ready = rx_ready;
  always @(negedge clk) begin
    rx_ready <= !receiver_stalls();
  end

  // Handshake monitors: accepted samples feed the predictor, accepted results are checked.
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) begin
      tracker.take_sample(in_if.accel_x, in_if.accel_y, in_if.accel_z, in_if.time_ms);
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      tracker.match_verdict(out_if.fall_detected, out_if.event_code, out_if.detector_mode);
    end
    if (rst_n && cfg_if.valid && cfg_if.ready) begin
      tracker.write_reg(cfg_if.index, cfg_if.data);
    end
  end

  // Holds one register write until it is taken; the caller lowers valid.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, level_t data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
  endtask

  task automatic apply_settings(settings_t s);
    write_reg(CFG_FREEFALL_LEVEL, s.ff);
    write_reg(CFG_IMPACT_LEVEL, s.imp);
    write_reg(CFG_VIOLENT_LEVEL, s.vio);
    write_reg(CFG_STABLE_LOW, s.lo);
    write_reg(CFG_STABLE_HIGH, s.hi);
    write_reg(CFG_FF_WINDOW_MS, s.win);
    write_reg(CFG_ORIENT_DELAY_MS, s.dly);
    cfg_if.valid <= 1'b0;
    n_settings++;
  endtask

  // Offers one sample after a random gap and waits until it is taken.
  task automatic send_sample(sample_t s);
    while (sender_idles()) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.accel_x <= s.x;
    in_if.accel_y <= s.y;
    in_if.accel_z <= s.z;
    in_if.time_ms <= s.t;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  // Sends the queued samples, then waits until every verdict has come back.
  task automatic run_queue();
    foreach (stim_q[i]) send_sample(stim_q[i]);
    in_if.valid <= 1'b0;
    stim_q.delete();
    while (tracker.pending() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic push_at(int x, int y, int z, time_t t);
    sample_t s;
    s.x = accel_t'(x);
    s.y = accel_t'(y);
    s.z = accel_t'(z);
    s.t = t;
    stim_q.push_back(s);
  endtask

  // Random vector whose magnitude falls in the band that the kind names.
  function automatic sample_t shape(kind_e k);
    sample_t s;
    int c[3];
    int ax;
    int mag;
    case (k)
      KIND_STABLE: begin
        for (int i = 0; i < 3; i++) c[i] = int'($urandom_range(0, 6000)) - 3000;
        ax = $urandom_range(0, 2);
        mag = 15400 + int'($urandom_range(0, 2000));
        c[ax] = $urandom_range(0, 1) ? mag : -mag;
      end
      KIND_FREEFALL: begin
        for (int i = 0; i < 3; i++) c[i] = int'($urandom_range(0, 4000)) - 2000;
      end
      KIND_IMPACT, KIND_VIOLENT: begin
        for (int i = 0; i < 3; i++) begin
          mag = (k == KIND_VIOLENT) ? int'($urandom_range(31000, 32767))
                                    : int'($urandom_range(29000, 32767));
          c[i] = $urandom_range(0, 1) ? mag : -mag;
        end
      end
      KIND_NOISE: begin
        for (int i = 0; i < 3; i++) c[i] = int'($urandom() & 32'hFFFF);
      end
      default: begin
        for (int i = 0; i < 3; i++) c[i] = 0;
      end
    endcase
    s.x = accel_t'(c[0]);
    s.y = accel_t'(c[1]);
    s.z = accel_t'(c[2]);
    s.t = '0;
    return s;
  endfunction

  task automatic push_kind(kind_e k, int unsigned step);
    sample_t s;
    s = shape(k);
    clock_ms = clock_ms + step;
    s.t = clock_ms;
    stim_q.push_back(s);
  endtask

  // Mostly short steps, now and then long ones, rarely a jump anywhere on the clock.
  function automatic int unsigned random_step();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, 40);
    if (r < 95) return $urandom_range(41, 600);
    if (r < 99) return $urandom_range(601, 70000);
    return $urandom();
  endfunction

  // Stable rest, free fall, impact, settling and the orientation check, with random
  // timing around the window and the delay; some sequences never see the impact.
  task automatic queue_fall_sequence();
    int unsigned win, dly, r;
    time_t imp_t;
    win = tracker.win_ms;
    dly = tracker.dly_ms;
    repeat ($urandom_range(1, 3)) push_kind(KIND_STABLE, random_step());
    repeat ($urandom_range(1, 3)) push_kind(KIND_FREEFALL, $urandom_range(0, win / 4));
    r = $urandom_range(0, 99);
    if (r < 80) begin
      // An impact just past the window still wins over the timeout.
      push_kind(KIND_IMPACT, (r < 8) ? win + 1 : $urandom_range(0, win / 4));
      imp_t = clock_ms;
      repeat ($urandom_range(0, 3)) begin
        r = $urandom_range(0, 99);
        push_kind(r < 15 ? KIND_VIOLENT : (r < 30 ? KIND_IMPACT : KIND_STABLE),
                  $urandom_range(0, dly / 4));
      end
      clock_ms = imp_t + dly + ($urandom_range(0, 1) ? 0 : $urandom_range(0, 50));
      r = $urandom_range(0, 99);
      push_kind(r < 80 ? KIND_STABLE : (r < 90 ? KIND_ZERO : KIND_NOISE), 0);
    end else begin
      repeat ($urandom_range(1, 4)) begin
        push_kind($urandom_range(0, 1) ? KIND_FREEFALL : KIND_STABLE,
                  $urandom_range(0, win / 2 + 1));
      end
      push_kind(KIND_STABLE, win + 1);
    end
  endtask

  task automatic queue_noise();
    kind_e k;
    repeat ($urandom_range(1, 5)) begin
      case ($urandom_range(0, 5))
        0: k = KIND_STABLE;
        1: k = KIND_FREEFALL;
        2: k = KIND_IMPACT;
        3: k = KIND_VIOLENT;
        4: k = KIND_ZERO;
        default: k = KIND_NOISE;
      endcase
      push_kind(k, random_step());
    end
  endtask

  task automatic run_random_phase(settings_t s, int unsigned quota, pace_e p);
    apply_settings(s);
    pace = p;
    clock_ms = $urandom();
    while (stim_q.size() < quota) begin
      if ($urandom_range(0, 99) < 75) queue_fall_sequence();
      else queue_noise();
    end
    run_queue();
    pace = PACE_FULL;
  endtask

  function automatic settings_t random_settings();
    settings_t s;
    s.ff  = level_t'($urandom_range(0, 20000));
    s.imp = level_t'($urandom_range(20000, 60000));
    s.vio = level_t'($urandom_range(30000, 131071));
    s.lo  = level_t'($urandom_range(5000, 16000));
    s.hi  = level_t'($urandom_range(16000, 30000));
    s.win = level_t'($urandom_range(0, 1000));
    s.dly = level_t'($urandom_range(0, 400));
    return s;
  endfunction

  initial begin
    settings_t s;
    time_t t0;
    in_if.valid <= 1'b0;
    in_if.accel_x <= '0;
    in_if.accel_y <= '0;
    in_if.accel_z <= '0;
    in_if.time_ms <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= '0;
    cfg_if.data <= '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed samples under the reset register values.
    t0 = 32'hFFFF_FF00;
    push_at(32767, 32767, 32767, 0);
    push_at(-32768, -32768, -32768, 1);
    push_at(0, 0, 13926, 2);           // on the lower band edge: not kept
    push_at(0, 0, 18842, 3);           // on the upper band edge: not kept
    push_at(0, 13927, 0, 4);           // kept as the reference
    push_at(0, 0, 0, t0);              // free fall just before the clock wraps
    push_at(100, 0, 0, t0 + 500);      // exactly at the window: still waiting
    push_at(100, 0, 0, t0 + 501);      // past the window across the wrap: timeout
    push_at(0, 0, 4914, 10);
    push_at(30000, -30000, 30000, 511); // late impact wins over the timeout
    push_at(0, 0, 16384, 710);
    push_at(0, 9000, 9000, 711);       // exactly 45 degrees: no fall
    push_at(0, 0, 0, 800);
    push_at(32767, 32767, 32767, 801);
    push_at(0, -16384, 0, 1001);       // opposite the reference: fall
    push_at(0, 0, 0, 1100);
    push_at(-32768, -32768, -32768, 1100);
    push_at(0, 0, 0, 1300);            // zero vector at the check: no fall
    push_at(16384, 0, 0, 1301);
    run_queue();

    // Overlapping levels: a stable sample also starts free fall; zero window, short delay.
    s.ff = 20000;
    s.imp = 30000;
    s.vio = 40000;
    s.lo = 10000;
    s.hi = 25000;
    s.win = 17'h10000;                 // top bit dropped: window of zero
    s.dly = 5;
    apply_settings(s);
    @(negedge clk);
    write_reg(CfgUnusedIdx, 17'h1FFFF);
    cfg_if.valid <= 1'b0;
    push_at(0, 0, 15000, 5000);
    push_at(32767, 32767, 32767, 5000);
    push_at(32767, 32767, 32767, 5005); // delay expired: checked before violent
    push_at(0, 0, 100, 5006);
    push_at(-32768, -32768, -32768, 5007);
    push_at(32767, 32767, 32767, 5011); // inside the delay: violent abort
    push_at(0, 0, 100, 5012);
    push_at(0, 0, 100, 5013);
    run_queue();

    // Random phases over reset, sensitive, extreme and random settings.
    s.ff = FreefallLevelRst;
    s.imp = ImpactLevelRst;
    s.vio = ViolentLevelRst;
    s.lo = StableLowRst;
    s.hi = StableHighRst;
    s.win = level_t'(FfWindowRst);
    s.dly = level_t'(OrientDelayRst);
    run_random_phase(s, 250, PACE_FULL);
    s.ff = 8000;
    s.imp = 30000;
    s.vio = 45000;
    s.lo = 12000;
    s.hi = 21000;
    s.win = 60;
    s.dly = 30;
    run_random_phase(s, 250, PACE_SENDER);
    s.ff = '0;
    s.imp = '0;
    s.vio = '0;
    s.lo = '0;
    s.hi = '0;
    s.win = '0;
    s.dly = '0;
    run_random_phase(s, 60, PACE_RECEIVER);
    s.ff = '1;
    s.imp = '1;
    s.vio = '1;
    s.lo = '1;
    s.hi = '1;
    s.win = '1;
    s.dly = '1;
    run_random_phase(s, 60, PACE_BOTH);
    for (int i = 0; i < 4; i++) run_random_phase(random_settings(), 200, pace_e'(i));

    $display("Covered %0d samples under %0d register settings with four pacing modes.",
             tracker.samples, n_settings);
    $display("Outcomes: %0d falls, %0d small angles, %0d violent aborts, %0d timeouts.",
             tracker.ev_seen[EV_FALL], tracker.ev_seen[EV_SMALL],
             tracker.ev_seen[EV_VIOLENT], tracker.ev_seen[EV_TIMEOUT]);
    if (tracker.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
